// File: sv/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Types, codes and constants shared by the message receiver files.
// ----------------------------------------------------------------------------
package fmr_pkg;

  // default and fixed sizes
  localparam int BUF_DEPTH_DEF = 64;
  localparam int TABLE_DEPTH   = 16;
  localparam int TIDX_W        = $clog2(TABLE_DEPTH);

  // payload widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int PIN_W   = 7;
  localparam int KIND_W  = 4;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 14;
  localparam int VER_W   = 7;
  localparam int LEN_W   = 7;

  // status bytes and nibbles
  localparam logic [3:0] ST_ANALOG_HI     = 4'hE;
  localparam logic [3:0] ST_DIGITAL_HI    = 4'h9;
  localparam logic [3:0] ST_REP_ANALOG_HI = 4'hC;
  localparam logic [3:0] ST_REP_DIGIT_HI  = 4'hD;
  localparam logic [7:0] ST_VERSION       = 8'hF9;
  localparam logic [7:0] ST_SYSEX         = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END     = 8'hF7;
  localparam logic [7:0] SX_FIRMWARE      = 8'h79;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE         = 2'd0,
    CMD_READ_ANALOG  = 2'd1,
    CMD_READ_DIGITAL = 2'd2
  } cmd_t;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ANALOG      = 4'd0,
    KIND_DIGITAL     = 4'd1,
    KIND_VERSION     = 4'd2,
    KIND_FIRMWARE    = 4'd3,
    KIND_SYSEX_OTHER = 4'd4,
    KIND_MSG_OTHER   = 4'd5,
    KIND_ANALOG_RD   = 4'd6,
    KIND_DIGITAL_RD  = 4'd7,
    KIND_RANGE       = 4'd8
  } kind_t;

  // one result
  typedef struct packed {
    kind_t              kind;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
    logic [VER_W-1:0]   version_major;
    logic [VER_W-1:0]   version_minor;
    logic [LEN_W-1:0]   message_length;
  } fmr_res_t;

  // completed message from the framer
  typedef struct packed {
    logic     done;
    fmr_res_t res;
  } fmr_msg_t;

endpackage

// File: sv/fmr_if.sv
// ----------------------------------------------------------------------------
// fmr_in_if / fmr_out_if
// Valid/ready channels for received items and for results.
// ----------------------------------------------------------------------------
interface fmr_in_if import fmr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;
  logic [PIN_W-1:0]  pin_index;

  modport source (output valid, output command, output rx_byte, output pin_index,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input pin_index,
                  output ready);
endinterface

interface fmr_out_if import fmr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CHAN_W-1:0]  channel;
  logic [VALUE_W-1:0] value;
  logic [VER_W-1:0]   version_major;
  logic [VER_W-1:0]   version_minor;
  logic [LEN_W-1:0]   message_length;

  modport source (output valid, output kind, output channel, output value,
                  output version_major, output version_minor, output message_length,
                  input ready);
  modport sink   (input valid, input kind, input channel, input value,
                  input version_major, input version_minor, input message_length,
                  output ready);
endinterface

// File: sv/fmr_framer.sv
// ----------------------------------------------------------------------------
// fmr_framer
// Frames received bytes by status byte and decodes each completed message.
// ----------------------------------------------------------------------------
module fmr_framer import fmr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  output fmr_msg_t          msg
);

  localparam int CW     = $clog2(BUF_DEPTH + 2);
  localparam int HDR_N  = 4;

  logic [CW-1:0]     count_r, exp_r;
  logic [CW-1:0]     exp_nxt, base, n;
  logic [BYTE_W-1:0] hdr_r   [HDR_N];
  logic [BYTE_W-1:0] hdr_nxt [HDR_N];
  logic [BYTE_W-1:0] bat     [HDR_N];
  logic              restart, store, is_three;
  logic [3:0]        hi;
  logic [BYTE_W-1:0] b0;

  // status classification and fill position
  always_comb begin
    hi      = rx_byte[7:4];
    restart = 1'b1;
    exp_nxt = exp_r;
    if (hi == ST_ANALOG_HI || hi == ST_DIGITAL_HI || rx_byte == ST_VERSION) begin
      exp_nxt = CW'(3);
    end else if (hi == ST_REP_ANALOG_HI || hi == ST_REP_DIGIT_HI) begin
      exp_nxt = CW'(2);
    end else if (rx_byte == ST_SYSEX) begin
      exp_nxt = CW'(BUF_DEPTH);
    end else if (rx_byte == ST_SYSEX_END) begin
      restart = 1'b0;
      exp_nxt = count_r + CW'(1);
    end else if (rx_byte[7]) begin
      exp_nxt = CW'(1);
    end else begin
      restart = 1'b0;
    end
    base  = restart ? '0 : count_r;
    store = (base < CW'(BUF_DEPTH));
    n     = store ? base + CW'(1) : base;
  end

  // only the first header bytes are ever decoded; later bytes need no storage
  always_comb begin
    for (int i = 0; i < HDR_N; i++) begin
      hdr_nxt[i] = (store && base == CW'(i)) ? rx_byte : hdr_r[i];
      bat[i]     = (CW'(i) < n) ? hdr_nxt[i] : '0;
    end
  end

  // decode of the completed message
  always_comb begin
    b0       = bat[0];
    is_three = (n == CW'(3));
    msg      = '0;
    msg.done = byte_valid && (n == exp_nxt);
    msg.res.kind           = KIND_MSG_OTHER;
    msg.res.message_length = LEN_W'(n);
    if (b0[7:4] == ST_ANALOG_HI && is_three) begin
      msg.res.kind    = KIND_ANALOG;
      msg.res.channel = b0[3:0];
      msg.res.value   = {bat[2][6:0], bat[1][6:0]};
    end else if (b0[7:4] == ST_DIGITAL_HI && is_three) begin
      msg.res.kind    = KIND_DIGITAL;
      msg.res.channel = b0[3:0];
      msg.res.value   = {bat[2][6:0], bat[1][6:0]};
    end else if (b0 == ST_VERSION && is_three) begin
      msg.res.kind          = KIND_VERSION;
      msg.res.version_major = bat[1][6:0];
      msg.res.version_minor = bat[2][6:0];
    end else if (b0 == ST_SYSEX && n != '0 && rx_byte == ST_SYSEX_END) begin
      // the last stored byte is always the one just taken
      if (n > CW'(2) && bat[1] == SX_FIRMWARE) begin
        msg.res.kind          = KIND_FIRMWARE;
        msg.res.version_major = (n > CW'(3)) ? bat[2][6:0] : '0;
        msg.res.version_minor = (n > CW'(4)) ? bat[3][6:0] : '0;
      end else begin
        msg.res.kind = KIND_SYSEX_OTHER;
      end
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      exp_r   <= '0;
    end else if (byte_valid) begin
      if (msg.done) begin
        count_r <= '0;
        exp_r   <= '0;
      end else begin
        count_r <= n;
        exp_r   <= exp_nxt;
      end
    end
  end

  // header bytes
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      for (int i = 0; i < HDR_N; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

endmodule

// File: sv/firmata_message_receiver.sv
// ----------------------------------------------------------------------------
// firmata_message_receiver
// Frames received bytes into messages, keeps analog and digital tables and
// answers table reads.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle. Each transaction is either
// a received serial byte or a read of the analog or digital table; a byte that
// completes a message and every read give one result, which appears on the
// output register the cycle after acceptance. Framing, decode and table access
// are combinational logic ahead of that register, and the input stays ready as
// long as the output register is empty or being emptied in the same cycle.
// Only the first four bytes of a message are kept, which is all the decode
// needs; BUF_DEPTH sets how many bytes a message may hold before further bytes
// are dropped and an unterminated sysex completes. Command code 3 is ignored.
module firmata_message_receiver import fmr_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  fmr_in_if.sink    in_stream,
  fmr_out_if.source out_stream
);

  logic               acc, byte_acc, res_valid;
  fmr_msg_t           msg;
  fmr_res_t           res, out_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] analog_r  [TABLE_DEPTH];
  logic [VALUE_W-1:0] digital_r [TABLE_DEPTH];
  logic [TIDX_W-1:0]  port;

  // handshake
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign acc      = in_stream.valid && in_stream.ready;
  assign byte_acc = acc && (in_stream.command == CMD_BYTE);

  // byte framing
  fmr_framer #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_acc),
    .rx_byte    (in_stream.rx_byte),
    .msg        (msg)
  );

  // result select for messages and table reads
  always_comb begin
    port      = in_stream.pin_index[PIN_W-1:3];
    res       = '0;
    res.kind  = KIND_RANGE;
    res_valid = 1'b0;
    case (in_stream.command)
      CMD_BYTE: begin
        res       = msg.res;
        res_valid = msg.done;
      end
      CMD_READ_ANALOG: begin
        res_valid = 1'b1;
        if (in_stream.pin_index < PIN_W'(TABLE_DEPTH)) begin
          res.kind    = KIND_ANALOG_RD;
          res.channel = CHAN_W'(in_stream.pin_index[TIDX_W-1:0]);
          res.value   = analog_r[in_stream.pin_index[TIDX_W-1:0]];
        end
      end
      CMD_READ_DIGITAL: begin
        res_valid = 1'b1;
        if ({1'b0, in_stream.pin_index} < (PIN_W+1)'(8 * TABLE_DEPTH)) begin
          res.kind    = KIND_DIGITAL_RD;
          res.channel = CHAN_W'(port);
          res.value   = VALUE_W'(digital_r[port][in_stream.pin_index[2:0]]);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // analog and digital tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        analog_r[i]  <= '0;
        digital_r[i] <= '0;
      end
    end else if (byte_acc && msg.done) begin
      if (msg.res.kind == KIND_ANALOG) begin
        analog_r[msg.res.channel[TIDX_W-1:0]] <= msg.res.value;
      end
      if (msg.res.kind == KIND_DIGITAL) begin
        digital_r[msg.res.channel[TIDX_W-1:0]] <= msg.res.value;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_r <= res;
    end
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.kind           = out_r.kind;
  assign out_stream.channel        = out_r.channel;
  assign out_stream.value          = out_r.value;
  assign out_stream.version_major  = out_r.version_major;
  assign out_stream.version_minor  = out_r.version_minor;
  assign out_stream.message_length = out_r.message_length;

endmodule
